FILE: rtl/core/wba_pkg.sv
// Package for the white background to alpha block: item types, the per-cell
// divider data type and the widths and arithmetic constants that the modules use.
// No dependencies.
package wba_pkg;

  localparam int unsigned PixW     = 8;
  localparam int unsigned NumLanes = 3;
  localparam int unsigned DivSteps = PixW;

  localparam logic [PixW-1:0] PixMax  = 8'd255;
  localparam logic [PixW-1:0] PixHalf = 8'd127;

  // x / 255 == (x * 32897) >> 23 for every 16-bit x.
  localparam logic [15:0] Recip255      = 16'd32897;
  localparam int unsigned Recip255Shift = 23;

  typedef struct packed {
    logic [PixW-1:0] red_in;
    logic [PixW-1:0] green_in;
    logic [PixW-1:0] blue_in;
    logic [PixW-1:0] alpha_in;
  } pix_in_t;

  typedef struct packed {
    logic [PixW-1:0] red_out;
    logic [PixW-1:0] green_out;
    logic [PixW-1:0] blue_out;
    logic [PixW-1:0] alpha_out;
  } pix_out_t;

  // One color lane of the shift-subtract divider. The low byte holds the
  // numerator bits still to be shifted in; quotient bits enter at its bottom.
  typedef struct packed {
    logic [PixW-1:0] rem;
    logic [PixW-1:0] lo;
  } div_lane_t;

  typedef struct packed {
    logic [PixW-1:0] k;
    logic [PixW-1:0] na;
    div_lane_t [NumLanes-1:0] lane;
  } cell_t;

endpackage

FILE: rtl/core/wba_front.sv
// Front end of the white background to alpha block: finds the white level,
// forms the new alpha and the divider numerators over two register stages.
// Depends on wba_pkg.
module wba_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  wba_pkg::pix_in_t pix_i,
  output logic             valid_o,
  output wba_pkg::cell_t   cell_o
);
  import wba_pkg::*;

  logic [PixW-1:0] white;
  logic [PixW-1:0] chan [NumLanes];

  logic            va_q;
  logic [PixW-1:0] k_a_d, k_a_q;
  logic [PixW-1:0] diff_a_d [NumLanes];
  logic [PixW-1:0] diff_a_q [NumLanes];
  logic [15:0]     ak_a_d, ak_a_q;

  logic            vb_q;
  cell_t           cell_b_d, cell_b_q;
  logic [31:0]     na_prod;
  logic [15:0]     num [NumLanes];

  assign chan[0] = pix_i.red_in;
  assign chan[1] = pix_i.green_in;
  assign chan[2] = pix_i.blue_in;

  always_comb begin
    logic [PixW-1:0] m;
    m = (chan[0] < chan[1]) ? chan[0] : chan[1];
    white = (m < chan[2]) ? m : chan[2];
    k_a_d = PixMax - white;
    for (int i = 0; i < NumLanes; i++) begin
      diff_a_d[i] = chan[i] - white;
    end
    ak_a_d = 16'(pix_i.alpha_in * k_a_d) + {8'd0, PixHalf};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    k_a_q    <= k_a_d;
    diff_a_q <= diff_a_d;
    ak_a_q   <= ak_a_d;
  end

  // Second stage: divide the alpha product by 255 and build numerators
  // (diff * 255 + k / 2) for the per-channel dividers.
  always_comb begin
    na_prod     = ak_a_q * Recip255;
    cell_b_d.k  = k_a_q;
    cell_b_d.na = na_prod[Recip255Shift +: PixW];
    for (int i = 0; i < NumLanes; i++) begin
      num[i] = {diff_a_q[i], 8'd0} - {8'd0, diff_a_q[i]} + {9'd0, k_a_q[PixW-1:1]};
      cell_b_d.lane[i].rem = num[i][15:8];
      cell_b_d.lane[i].lo  = num[i][7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_b_q <= cell_b_d;
  end

  assign valid_o = vb_q;
  assign cell_o  = cell_b_q;

endmodule

FILE: rtl/core/wba_cell.sv
// One cell of the divider chain: shifts one numerator bit into each lane's
// remainder, subtracts k when it fits and records one quotient bit.
// Depends on wba_pkg.
module wba_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  wba_pkg::cell_t cell_i,
  output logic           valid_o,
  output wba_pkg::cell_t cell_o
);
  import wba_pkg::*;

  logic  valid_q;
  cell_t cell_d, cell_q;

  always_comb begin
    logic [PixW:0]   trial;
    logic [PixW:0]   diff;
    logic            q_bit;
    cell_d = cell_i;
    for (int i = 0; i < NumLanes; i++) begin
      trial = {cell_i.lane[i].rem, cell_i.lane[i].lo[PixW-1]};
      diff  = trial - {1'b0, cell_i.k};
      q_bit = (trial >= {1'b0, cell_i.k});
      cell_d.lane[i].rem = q_bit ? diff[PixW-1:0] : trial[PixW-1:0];
      cell_d.lane[i].lo  = {cell_i.lane[i].lo[PixW-2:0], q_bit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;

endmodule

FILE: rtl/core/white_background_to_alpha_top.sv
// Top level of the white background to alpha block: front end, a chain of
// divider cells and the output register. Depends on wba_pkg, wba_front and
// wba_cell.
//
// Usage: drive a pixel on pix_i and raise start; the item is taken at any
// rising edge where start is high and busy is low. busy stays low, so a new
// pixel may be taken in every cycle, one pixel per cycle sustained.
// Each pixel goes through two front stages (white level, alpha product,
// alpha / 255 and numerators), eight divider cells that each produce one
// quotient bit for all three colors at once, and the output register.
// The result appears on pix_o with out_valid_o high for exactly one cycle,
// after the two front stages, the eight divider cells and the output
// register; results keep input order.
// The receiver has no way to hold results off and must take each one in
// the cycle it is shown. Reset clears all valid flags, so no result is
// shown until a new item arrives; no state carries from pixel to pixel.
// A pixel whose new alpha is zero, pure white included, comes out as zero.
module white_background_to_alpha_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  wba_pkg::pix_in_t  pix_i,
  output logic              out_valid_o,
  output wba_pkg::pix_out_t pix_o
);
  import wba_pkg::*;

  logic  chain_valid [DivSteps+1];
  cell_t chain_cell  [DivSteps+1];

  logic     out_valid_q;
  pix_out_t pix_d, pix_q;

  assign busy = 1'b0;

  wba_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .pix_i   (pix_i),
    .valid_o (chain_valid[0]),
    .cell_o  (chain_cell[0])
  );

  for (genvar g = 0; g < DivSteps; g++) begin : g_cell
    wba_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[g]),
      .cell_i  (chain_cell[g]),
      .valid_o (chain_valid[g+1]),
      .cell_o  (chain_cell[g+1])
    );
  end

  // A zero alpha also covers k equal to zero, where the quotients are junk.
  always_comb begin
    if (chain_cell[DivSteps].na == '0) begin
      pix_d = '0;
    end else begin
      pix_d.red_out   = chain_cell[DivSteps].lane[0].lo;
      pix_d.green_out = chain_cell[DivSteps].lane[1].lo;
      pix_d.blue_out  = chain_cell[DivSteps].lane[2].lo;
      pix_d.alpha_out = chain_cell[DivSteps].na;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= chain_valid[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
  end

  assign out_valid_o = out_valid_q;
  assign pix_o       = pix_q;

  // A transparent result carries no color.
  a_zero_alpha_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && pix_o.alpha_out == '0) |->
      (pix_o.red_out == '0 && pix_o.green_out == '0 && pix_o.blue_out == '0))
    else $error("transparent result has nonzero color");

  // The channel that set the white level always comes out as zero.
  a_white_channel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (pix_o.red_out == '0 || pix_o.green_out == '0 || pix_o.blue_out == '0))
    else $error("no color channel is zero after white removal");

  // After the last cell every lane's remainder is below the divisor.
  a_rem_below_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chain_valid[DivSteps] && chain_cell[DivSteps].k != '0) |->
      (chain_cell[DivSteps].lane[0].rem < chain_cell[DivSteps].k &&
       chain_cell[DivSteps].lane[1].rem < chain_cell[DivSteps].k &&
       chain_cell[DivSteps].lane[2].rem < chain_cell[DivSteps].k))
    else $error("divider remainder not reduced below k");

  // An item entering the chain leaves it after passing through all the cells.
  a_chain_delay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(chain_valid[0]) |-> ##8 chain_valid[DivSteps])
    else $error("item lost in the divider chain");

endmodule

FILE: tb/sv/white_background_to_alpha_checker.sv
// Checker for the white background to alpha block: watches the pixel and
// result channels, predicts each result and compares it field by field.
// Depends on wba_pkg.
`timescale 1ns / 100ps

module white_background_to_alpha_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  wba_pkg::pix_in_t  pix_in_i,
  input  logic              out_valid_i,
  input  wba_pkg::pix_out_t pix_out_i,
  output int unsigned       accepted_o,
  output int unsigned       pending_o,
  output int unsigned       compared_o,
  output int unsigned       cleared_o,
  output int unsigned       errors_o
);
  import wba_pkg::*;

  pix_out_t    expected_pixels[$];
  int unsigned n_accepted = 0;
  int unsigned n_pending  = 0;
  int unsigned n_compared = 0;
  int unsigned n_cleared  = 0;
  int unsigned n_errors   = 0;

  assign accepted_o = n_accepted;
  assign pending_o  = n_pending;
  assign compared_o = n_compared;
  assign cleared_o  = n_cleared;
  assign errors_o   = n_errors;

  // Stretches the distance of a channel above the white level over the full range.
  function automatic logic [PixW-1:0] rescale_channel(int unsigned chan, int unsigned white,
                                                      int unsigned k);
    int unsigned q;
    if (k == 0 || chan < white) return '0;
    q = ((chan - white) * 255 + k / 2) / k;
    return (q > 255) ? PixMax : q[PixW-1:0];
  endfunction

  function automatic pix_out_t unwhite_pixel(pix_in_t p);
    int unsigned white;
    int unsigned k;
    int unsigned na;
    pix_out_t    r;
    white = 32'(p.red_in);
    if (32'(p.green_in) < white) white = 32'(p.green_in);
    if (32'(p.blue_in) < white) white = 32'(p.blue_in);
    k  = 255 - white;
    na = (32'(p.alpha_in) * k + 127) / 255;
    r  = '0;
    // A pixel that ends up with no alpha left is cleared entirely.
    if (na != 0 && k != 0) begin
      r.red_out   = rescale_channel(32'(p.red_in), white, k);
      r.green_out = rescale_channel(32'(p.green_in), white, k);
      r.blue_out  = rescale_channel(32'(p.blue_in), white, k);
      r.alpha_out = na[PixW-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t: result %0d: %s got %0d, expected %0d", $realtime, n_compared, what, got,
             want);
    n_errors++;
  endtask

  always @(posedge clk_i) begin : watch_channels
    pix_out_t want;
    if (rst_ni) begin
      if (start_i && !busy_i) begin
        expected_pixels.push_back(unwhite_pixel(pix_in_i));
        n_accepted++;
      end
      if (out_valid_i) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("result with no item outstanding", pix_out_i, 0);
        end else begin
          want = expected_pixels.pop_front();
          if (pix_out_i.red_out !== want.red_out)
            report_mismatch("red_out", 32'(pix_out_i.red_out), 32'(want.red_out));
          if (pix_out_i.green_out !== want.green_out)
            report_mismatch("green_out", 32'(pix_out_i.green_out), 32'(want.green_out));
          if (pix_out_i.blue_out !== want.blue_out)
            report_mismatch("blue_out", 32'(pix_out_i.blue_out), 32'(want.blue_out));
          if (pix_out_i.alpha_out !== want.alpha_out)
            report_mismatch("alpha_out", 32'(pix_out_i.alpha_out), 32'(want.alpha_out));
          if (want.alpha_out == 0) n_cleared++;
          n_compared++;
        end
      end
      n_pending = expected_pixels.size();
    end
  end

endmodule

FILE: tb/sv/white_background_to_alpha_top_tb.sv
// Testbench top for the white background to alpha block: clock, reset and
// pixel stimulus; checking is done by white_background_to_alpha_checker.
// Depends on wba_pkg, the block and the checker.
`timescale 1ns / 100ps

module white_background_to_alpha_top_tb;
  import wba_pkg::*;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        start      = 1'b0;
  pix_in_t     pixel_in   = '0;
  logic        busy;
  logic        out_valid;
  pix_out_t    pixel_out;
  int unsigned n_accepted;
  int unsigned n_pending;
  int unsigned n_compared;
  int unsigned n_cleared;
  int unsigned n_errors;

  always #5 clk_i = ~clk_i;

  white_background_to_alpha_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .pix_i       (pixel_in),
    .out_valid_o (out_valid),
    .pix_o       (pixel_out)
  );

  white_background_to_alpha_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .pix_in_i    (pixel_in),
    .out_valid_i (out_valid),
    .pix_out_i   (pixel_out),
    .accepted_o  (n_accepted),
    .pending_o   (n_pending),
    .compared_o  (n_compared),
    .cleared_o   (n_cleared),
    .errors_o    (n_errors)
  );

  // Called and returns at a falling edge; holds the item until it is taken.
  task automatic drive_pixel(input pix_in_t p, input int unsigned idle_pct);
    int unsigned target;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    target = n_accepted + 1;
    start    <= 1'b1;
    pixel_in <= p;
    do @(negedge clk_i); while (n_accepted != target);
  endtask

  // Plain random pixels (the largest share), plus pixels close to white, tiny alpha,
  // grays and one-step-from-white pixels where rounding is tightest.
  function automatic pix_in_t random_pixel();
    int unsigned sel;
    int unsigned white;
    pix_in_t     p;
    sel = $urandom_range(99);
    p   = pix_in_t'($urandom);
    if (sel < 40) begin
      return p;
    end else if (sel < 60) begin
      white       = $urandom_range(255, 200);
      p.red_in    = 8'($urandom_range(255, white));
      p.green_in  = 8'($urandom_range(255, white));
      p.blue_in   = 8'($urandom_range(255, white));
      case ($urandom_range(2))
        0:       p.red_in   = 8'(white);
        1:       p.green_in = 8'(white);
        default: p.blue_in  = 8'(white);
      endcase
    end else if (sel < 75) begin
      p.alpha_in = 8'($urandom_range(8));
    end else if (sel < 90) begin
      white      = $urandom_range(255);
      p.red_in   = 8'(white);
      p.green_in = 8'(white);
      p.blue_in  = 8'(white);
    end else begin
      p.red_in   = 8'($urandom_range(255, 254));
      p.green_in = 8'($urandom_range(255, 254));
      p.blue_in  = 8'($urandom_range(255, 254));
    end
    return p;
  endfunction

  initial begin : stimulus
    int unsigned idle_pct;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Fields packed as red, green, blue, alpha.
    drive_pixel(32'h00000000, 0);  // black, no alpha
    drive_pixel(32'h000000FF, 0);  // opaque black
    drive_pixel(32'hFFFFFFFF, 0);  // pure white clears the pixel
    drive_pixel(32'hFFFFFF00, 0);
    drive_pixel(32'hFF0000FF, 0);
    drive_pixel(32'h00FF00FF, 0);
    drive_pixel(32'h0000FFFF, 0);
    drive_pixel(32'hFFFFFEFF, 0);  // darkness of one
    drive_pixel(32'hFEFEFEFF, 0);
    drive_pixel(32'h80808001, 0);  // alpha rounds to zero
    drive_pixel(32'h00000001, 0);  // alpha just survives
    drive_pixel(32'hC8643280, 0);
    drive_pixel(32'hFF800080, 0);
    drive_pixel(32'h55AA55AA, 0);
    drive_pixel(32'hAA55AA55, 0);
    drive_pixel(32'hFFFEFDC8, 0);
    drive_pixel(32'h7F7F7F02, 0);
    drive_pixel(32'h010203FF, 0);
    drive_pixel(32'hFF00FF7F, 0);
    drive_pixel(32'h0AFA8201, 0);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 18 : (phase == 1) ? 74 : 0;
      repeat (210) drive_pixel(random_pixel(), idle_pct);
    end
    start <= 1'b0;

    while (n_pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("Sent %0d pixels: corner cases, then random ones at sender idle rates of 18, 74, 0%%.",
             n_accepted);
    $display("Compared %0d results, %0d of them cleared to full transparency.", n_compared,
             n_cleared);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
